FILE: rtl/tla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_pkg: shared types and constants
// Command and status types between controller and datapath, field widths
// and op codes of the linear attention block.
// ----------------------------------------------------------------------------
package tla_pkg;

  // field widths
  localparam int IDX_W  = 4;
  localparam int DATA_W = 16;
  localparam int CNT_W  = 5;
  localparam int SK_W   = 32;
  localparam int KS_W   = 40;
  localparam int KV_W   = 56;
  localparam int FRAC_W = 12;
  localparam int MB_W   = KV_W - FRAC_W;
  localparam int PROD_W = DATA_W + MB_W;
  localparam int ACC_W  = 64;
  localparam int QUO_W  = 15;
  localparam int REM_W  = ACC_W + QUO_W - 1;
  localparam int MAX_DIM = 2 ** IDX_W;

  // request op codes
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic signed [DATA_W-1:0] SAT_POS = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] SAT_NEG = 16'sh8000;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_QSTORE,
    CMD_KEY_MUL,
    CMD_KEY_WR,
    CMD_VAL,
    CMD_DEN_CLR,
    CMD_DEN,
    CMD_DEN_EPS,
    CMD_NUM,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_PUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/tla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/tla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_ctrl: sequencer
// Decodes requests and steps the datapath through key, value and query
// work, one row per cycle.
// ----------------------------------------------------------------------------
module tla_ctrl #(
  parameter int KEY_DIM = 16,
  parameter int VALUE_DIM = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [tla_pkg::IDX_W-1:0]  elem_index,
  input  tla_pkg::stat_t             stat,
  output tla_pkg::cmd_t              cmd
);
  import tla_pkg::*;

  localparam int KD_EFF = (KEY_DIM < MAX_DIM) ? KEY_DIM : MAX_DIM;
  localparam int VD_EFF = (VALUE_DIM < MAX_DIM) ? VALUE_DIM : MAX_DIM;
  localparam logic [CNT_W-1:0] KD_C = CNT_W'(KD_EFF);
  localparam logic [CNT_W-1:0] KD_LAST = CNT_W'(KD_EFF - 1);
  localparam logic [CNT_W-1:0] NUM_END = CNT_W'(KD_EFF + 1);
  localparam logic [CNT_W-1:0] DIV_END = CNT_W'(QUO_W - 1);
  localparam logic [IDX_W-1:0] VD_LAST = IDX_W'(VD_EFF - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_KEY_MUL, S_KEY_WR, S_VAL, S_DEN_CLR, S_DEN, S_DEN_EPS,
    S_NUM, S_DIV_INIT, S_DIV, S_PUSH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] col;
  logic [CNT_W-1:0] idx_ext;
  logic             key_ok;
  logic             val_ok;

  assign idx_ext  = {1'b0, elem_index};
  assign key_ok   = idx_ext < KD_C;
  assign val_ok   = idx_ext < CNT_W'(VD_EFF);
  assign in_stall = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd.kind = CMD_NONE;
    cmd.row  = cnt[IDX_W-1:0];
    cmd.col  = col;
    case (state)
      S_IDLE: begin
        cmd.col = elem_index;
        if (in_valid) begin
          case (op)
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_KEY:   if (key_ok) cmd.kind = CMD_LOAD;
            OP_VALUE: if (val_ok) cmd.kind = CMD_LOAD;
            OP_QUERY: if (key_ok) cmd.kind = CMD_QSTORE;
            default:  cmd.kind = CMD_NONE;
          endcase
        end
      end
      S_KEY_MUL:  cmd.kind = CMD_KEY_MUL;
      S_KEY_WR:   cmd.kind = CMD_KEY_WR;
      S_VAL:      if (cnt < KD_C) cmd.kind = CMD_VAL;
      S_DEN_CLR:  cmd.kind = CMD_DEN_CLR;
      S_DEN:      if (cnt < KD_C) cmd.kind = CMD_DEN;
      S_DEN_EPS:  cmd.kind = CMD_DEN_EPS;
      S_NUM:      if (cnt < KD_C) cmd.kind = CMD_NUM;
      S_DIV_INIT: cmd.kind = CMD_DIV_INIT;
      S_DIV:      cmd.kind = CMD_DIV_STEP;
      S_PUSH:     if (stat.out_free) cmd.kind = CMD_PUSH;
      default:    cmd.kind = CMD_NONE;
    endcase
  end

  // state, row counter and column
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      col   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            col <= elem_index;
            case (op)
              OP_KEY:   if (key_ok) state <= S_KEY_MUL;
              OP_VALUE: if (val_ok) state <= S_VAL;
              OP_QUERY: if (key_ok && idx_ext == KD_LAST) state <= S_DEN_CLR;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_KEY_MUL: state <= S_KEY_WR;
        S_KEY_WR:  state <= S_IDLE;
        S_VAL: begin
          cnt <= cnt + 1'b1;
          if (cnt == KD_C) state <= S_IDLE;
        end
        S_DEN_CLR: begin
          cnt   <= '0;
          state <= S_DEN;
        end
        S_DEN: begin
          cnt <= cnt + 1'b1;
          if (cnt == KD_C) state <= S_DEN_EPS;
        end
        S_DEN_EPS: begin
          cnt   <= '0;
          col   <= '0;
          state <= S_NUM;
        end
        S_NUM: begin
          cnt <= cnt + 1'b1;
          if (cnt == NUM_END) state <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_END) state <= S_PUSH;
        end
        S_PUSH: begin
          if (stat.out_free) begin
            cnt <= '0;
            if (col == VD_LAST) begin
              state <= S_IDLE;
            end else begin
              col   <= col + 1'b1;
              state <= S_NUM;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tla_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tla_datapath: storage and arithmetic
// Key, key-sum and query registers, the KV matrix RAM, one shared
// multiplier, accumulators, a restoring divider and the output register.
// ----------------------------------------------------------------------------
module tla_datapath #(
  parameter int KEY_DIM = 16,
  parameter int VALUE_DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tla_pkg::cmd_t                      cmd,
  output tla_pkg::stat_t                     stat,
  input  logic signed [tla_pkg::DATA_W-1:0]  in_datum,
  input  logic signed [tla_pkg::DATA_W-1:0]  in_temperature,
  input  logic                               cfg_we,
  input  logic [tla_pkg::DATA_W-1:0]         cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tla_pkg::IDX_W-1:0]          out_channel,
  output logic signed [tla_pkg::DATA_W-1:0]  out_result,
  output logic                               out_last,
  output logic                               out_fault
);
  import tla_pkg::*;

  localparam int KD_EFF = (KEY_DIM < MAX_DIM) ? KEY_DIM : MAX_DIM;
  localparam int VD_EFF = (VALUE_DIM < MAX_DIM) ? VALUE_DIM : MAX_DIM;
  localparam int DEPTH  = KD_EFF * VD_EFF;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KA_W   = (KD_EFF > 1) ? $clog2(KD_EFF) : 1;
  localparam logic [IDX_W-1:0] VD_LAST = IDX_W'(VD_EFF - 1);

  function automatic logic [ADDR_W-1:0] kv_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    int a;
    a = int'(r) * VD_EFF + int'(c);
    return ADDR_W'(a);
  endfunction

  logic [DATA_W-1:0]        eps;
  logic signed [DATA_W-1:0] lat_d;
  logic signed [DATA_W-1:0] lat_t;
  logic signed [SK_W-1:0]   sk [KD_EFF];
  logic signed [KS_W-1:0]   ks [KD_EFF];
  logic signed [DATA_W-1:0] qs [KD_EFF];
  logic [DEPTH-1:0]         kv_vld;
  logic                     rd_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  den;
  logic signed [ACC_W-1:0]  num;
  cmd_kind_t                s1_kind;
  logic [IDX_W-1:0]         s1_row;
  logic [IDX_W-1:0]         s1_col;
  logic                     s2_num;
  logic                     neg;
  logic                     ovf;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         dsh;
  logic [QUO_W-1:0]         quo;

  logic [KA_W-1:0]          ks_idx;
  logic [KA_W-1:0]          q_idx;
  logic [KV_W-1:0]          kv_rdata;
  logic signed [KV_W-1:0]   kv_eff;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [KS_W:0]     ks_sum;
  logic signed [KS_W-1:0]   ks_sat;
  logic signed [KV_W:0]     kv_sum;
  logic [KV_W-1:0]          kv_sat;
  logic                     kv_we;
  logic [ADDR_W-1:0]        raddr;
  logic [ADDR_W-1:0]        waddr;
  logic [ACC_W-1:0]         num_mag;
  logic [ACC_W-1:0]         den_mag;
  logic                     fault;
  logic signed [DATA_W-1:0] res;

  assign stat.out_free = !out_valid || !out_stall;

  // register file addressing
  assign ks_idx = (cmd.kind == CMD_KEY_WR) ? cmd.col[KA_W-1:0] : cmd.row[KA_W-1:0];
  assign q_idx  = (s1_kind == CMD_NUM) ? s1_row[KA_W-1:0] : cmd.row[KA_W-1:0];
  assign kv_eff = rd_vld ? $signed(kv_rdata) : '0;

  // shared multiplier operand select
  always_comb begin
    mul_a = lat_d;
    mul_b = {{(MB_W-DATA_W){lat_t[DATA_W-1]}}, lat_t};
    case (cmd.kind)
      CMD_VAL: mul_b = {{(MB_W-SK_W){sk[cmd.row[KA_W-1:0]][SK_W-1]}},
                        sk[cmd.row[KA_W-1:0]]};
      CMD_DEN: begin
        mul_a = qs[q_idx];
        mul_b = {{(MB_W-KS_W){ks[ks_idx][KS_W-1]}}, ks[ks_idx]};
      end
      default: mul_b = {{(MB_W-DATA_W){lat_t[DATA_W-1]}}, lat_t};
    endcase
    // floor(kv / 2^12) times the query element
    if (s1_kind == CMD_NUM) begin
      mul_a = qs[q_idx];
      mul_b = kv_eff[KV_W-1:FRAC_W];
    end
  end

  // saturating key-sum update
  always_comb begin
    ks_sum = {ks[ks_idx][KS_W-1], ks[ks_idx]} +
             {{(KS_W+1-SK_W){prod[SK_W-1]}}, prod[SK_W-1:0]};
    if (ks_sum[KS_W] != ks_sum[KS_W-1]) begin
      ks_sat = {ks_sum[KS_W], {(KS_W-1){!ks_sum[KS_W]}}};
    end else begin
      ks_sat = ks_sum[KS_W-1:0];
    end
  end

  // saturating KV update, written in the cycle after the read
  always_comb begin
    kv_sum = {kv_eff[KV_W-1], kv_eff} +
             {{(KV_W+1-SK_W-DATA_W){prod[SK_W+DATA_W-1]}}, prod[SK_W+DATA_W-1:0]};
    if (kv_sum[KV_W] != kv_sum[KV_W-1]) begin
      kv_sat = {kv_sum[KV_W], {(KV_W-1){!kv_sum[KV_W]}}};
    end else begin
      kv_sat = kv_sum[KV_W-1:0];
    end
  end

  assign kv_we = (s1_kind == CMD_VAL);
  assign raddr = kv_addr(cmd.row, cmd.col);
  assign waddr = kv_addr(s1_row, s1_col);

  tla_ram #(
    .WIDTH (KV_W),
    .DEPTH (DEPTH)
  ) u_kv_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (waddr),
    .wdata (kv_sat),
    .raddr (raddr),
    .rdata (kv_rdata)
  );

  // divider operands and result
  assign num_mag = num[ACC_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[ACC_W-1] ? (~den + 1'b1) : den;
  assign fault   = (den == '0);

  always_comb begin
    if (fault) begin
      res = '0;
    end else if (ovf) begin
      res = neg ? SAT_NEG : SAT_POS;
    end else if (neg) begin
      res = -$signed({1'b0, quo});
    end else begin
      res = $signed({1'b0, quo});
    end
  end

  // control state and zero-reset stores
  always_ff @(posedge clk) begin
    if (rst) begin
      eps       <= DATA_W'(1);
      kv_vld    <= '0;
      s1_kind   <= CMD_NONE;
      s2_num    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < KD_EFF; i++) ks[i] <= '0;
    end else begin
      if (cfg_we) eps <= cfg_wdata;
      s1_kind <= cmd.kind;
      s2_num  <= (s1_kind == CMD_NUM);
      if (cmd.kind == CMD_CLEAR) begin
        kv_vld <= '0;
        for (int i = 0; i < KD_EFF; i++) ks[i] <= '0;
      end else begin
        if (kv_we) kv_vld[waddr] <= 1'b1;
        if (cmd.kind == CMD_KEY_WR) ks[ks_idx] <= ks_sat;
      end
      if (cmd.kind == CMD_PUSH) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_row <= cmd.row;
    s1_col <= cmd.col;
    rd_vld <= kv_vld[raddr];
    prod   <= mul_a * mul_b;
    case (cmd.kind)
      CMD_LOAD: begin
        lat_d <= in_datum;
        lat_t <= in_temperature;
      end
      CMD_QSTORE: qs[cmd.col[KA_W-1:0]] <= in_datum;
      CMD_KEY_WR: sk[cmd.col[KA_W-1:0]] <= prod[SK_W-1:0];
      CMD_DEN_CLR: begin
        den <= '0;
        num <= '0;
      end
      CMD_DEN_EPS: den <= den + $signed({{(ACC_W-DATA_W){1'b0}}, eps});
      CMD_DIV_INIT: begin
        neg <= num[ACC_W-1] ^ den[ACC_W-1];
        ovf <= {3'b000, num_mag} >= {den_mag, 3'b000};
        rem <= REM_W'({num_mag, {FRAC_W{1'b0}}});
        dsh <= {den_mag, {(QUO_W-1){1'b0}}};
        quo <= '0;
      end
      CMD_DIV_STEP: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      CMD_PUSH: begin
        num         <= '0;
        out_channel <= cmd.col;
        out_result  <= res;
        out_last    <= (cmd.col == VD_LAST);
        out_fault   <= fault;
      end
      default: lat_d <= lat_d;
    endcase
    if (s1_kind == CMD_DEN) den <= den + ACC_W'(prod);
    if (s2_num) num <= num + ACC_W'(prod);
  end

endmodule

`default_nettype wire

FILE: rtl/temperature_linear_attention.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_linear_attention: causal linear attention recurrence
// Keys scaled by temperature feed a key sum and a KV matrix; the last query
// element yields one saturated Q4.12 output per value channel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_stall  | op, elem_index, datum, temperature
//  out     | out       | out_valid / out_stall| channel, result_value, last, divide_fault
//  cfg     | in        | cfg_we               | cfg_wdata (eps_bias)
//
// Clear, ignored and non-final query requests stay idle; a key request
// multiplies and then writes its key sum; a value request loops over the key
// rows. The final query runs the denominator pass, then for each channel the
// dot product, the divider and the push; the shared multiplier and one KV RAM port set the row loops.
// Reset clears key sums and KV valid bits at once; no clearing pass.
// A stalled output holds the sequencer in its push step.
// ----------------------------------------------------------------------------
module temperature_linear_attention #(
  parameter int KEY_DIM = 16,
  parameter int VALUE_DIM = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic [tla_pkg::IDX_W-1:0]          elem_index,
  input  logic signed [tla_pkg::DATA_W-1:0]  datum,
  input  logic signed [tla_pkg::DATA_W-1:0]  temperature,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tla_pkg::IDX_W-1:0]          channel,
  output logic signed [tla_pkg::DATA_W-1:0]  result_value,
  output logic                               last,
  output logic                               divide_fault,
  input  logic                               cfg_we,
  input  logic [tla_pkg::DATA_W-1:0]         cfg_wdata
);
  import tla_pkg::*;

  localparam int VD_EFF = (VALUE_DIM < MAX_DIM) ? VALUE_DIM : MAX_DIM;

  cmd_t  cmd;
  stat_t stat;

  tla_ctrl #(
    .KEY_DIM   (KEY_DIM),
    .VALUE_DIM (VALUE_DIM)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .elem_index (elem_index),
    .stat       (stat),
    .cmd        (cmd)
  );

  tla_datapath #(
    .KEY_DIM   (KEY_DIM),
    .VALUE_DIM (VALUE_DIM)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_datum       (datum),
    .in_temperature (temperature),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (channel),
    .out_result     (result_value),
    .out_last       (last),
    .out_fault      (divide_fault)
  );

  // a faulted result carries zero
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_fault) |-> (result_value == '0))
    else $error("faulted result not zero");

  // the final result of a step is the last value channel
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (channel == IDX_W'(VD_EFF - 1)))
    else $error("last flag on wrong channel");

  // a clear keeps the sequencer idle
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == OP_CLEAR) |=> !in_stall)
    else $error("clear did not return to idle");

endmodule

`default_nettype wire

FILE: dv/tla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tla_checker: output predictor and scoreboard for temperature_linear_attention
// Watches the request, result and configuration ports, keeps its own copy of
// the attention state, predicts the result vector of every final query and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tla_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic [3:0]         elem_index,
  input  logic signed [15:0] datum,
  input  logic signed [15:0] temperature,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [3:0]         channel,
  input  logic signed [15:0] result_value,
  input  logic               last,
  input  logic               divide_fault,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output int                 fails,
  output int                 pending,
  output int                 results_seen,
  output int                 faults_seen,
  output int                 sats_seen
);
  import tla_pkg::*;

  localparam int DIM = 16;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [3:0]         chan;
    logic signed [15:0] value;
    logic               is_last;
    logic               fault;
  } attn_out_t;

  // mirrored attention state
  longint            scaled_key [DIM];
  longint            key_acc [DIM];
  longint            kv_acc [DIM][DIM];
  longint            query_vec [DIM];
  logic [15:0]       eps_reg;
  attn_out_t         expected_outputs [$];

  assign pending = expected_outputs.size();

  task automatic report_mismatch(input string msg);
    if (fails < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fails++;
  endtask

  function automatic longint clamp_signed(input longint x, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // |num|*2^12/|den| truncated, signed, saturated to Q4.12
  function automatic logic signed [15:0] q12_quotient(input longint num, input longint den);
    logic                neg;
    longint unsigned     un;
    longint unsigned     ud;
    longint unsigned     rem;
    longint unsigned     mag;
    int                  b;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    mag = un / ud;
    rem = un % ud;
    if (mag >= 8) return neg ? SAT_NEG : SAT_POS;
    for (b = 0; b < FRAC_W; b++) begin
      rem = rem << 1;
      mag = mag << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        mag = mag | 1;
      end
    end
    if (neg) return (mag > 32768) ? SAT_NEG : -$signed(mag[15:0]);
    return (mag > 32767) ? SAT_POS : $signed(mag[15:0]);
  endfunction

  task automatic clear_attention();
    for (int i = 0; i < DIM; i++) begin
      scaled_key[i] = 0;
      key_acc[i]    = 0;
      query_vec[i]  = 0;
      for (int j = 0; j < DIM; j++) kv_acc[i][j] = 0;
    end
  endtask

  // apply one accepted request to the mirrored state
  task automatic apply_request(input logic [1:0] code, input logic [3:0] idx,
                               input longint d, input longint t);
    longint    den;
    longint    num;
    attn_out_t o;
    case (code)
      OP_CLEAR: clear_attention();
      OP_KEY: begin
        scaled_key[idx] = d * t;
        key_acc[idx] = clamp_signed(key_acc[idx] + scaled_key[idx], KS_W);
      end
      OP_VALUE: begin
        for (int i = 0; i < DIM; i++)
          kv_acc[i][idx] = clamp_signed(kv_acc[i][idx] + scaled_key[i] * d, KV_W);
      end
      default: begin
        query_vec[idx] = d;
        if (idx == DIM - 1) begin
          den = 0;
          for (int i = 0; i < DIM; i++) den += query_vec[i] * key_acc[i];
          den += longint'(eps_reg);
          for (int j = 0; j < DIM; j++) begin
            num = 0;
            for (int i = 0; i < DIM; i++) num += query_vec[i] * (kv_acc[i][j] >>> FRAC_W);
            o.chan    = 4'(j);
            o.is_last = (j == DIM - 1);
            o.fault   = (den == 0);
            o.value   = o.fault ? 16'sd0 : q12_quotient(num, den);
            expected_outputs.push_back(o);
          end
        end
      end
    endcase
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    attn_out_t exp_o;
    if (rst) begin
      clear_attention();
      eps_reg = 16'd1;
      expected_outputs.delete();
    end else begin
      if (cfg_we) eps_reg = cfg_wdata;
      if (in_valid && !in_stall)
        apply_request(op, elem_index, longint'(datum), longint'(temperature));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (divide_fault) faults_seen++;
        if (result_value == SAT_POS || result_value == SAT_NEG) sats_seen++;
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected result ch=%0d val=%0d", channel,
                                    result_value));
        end else begin
          exp_o = expected_outputs.pop_front();
          if (channel !== exp_o.chan)
            report_mismatch($sformatf("channel got %0d exp %0d", channel, exp_o.chan));
          if (result_value !== exp_o.value)
            report_mismatch($sformatf("ch %0d result got %0d exp %0d", exp_o.chan,
                                      result_value, exp_o.value));
          if (last !== exp_o.is_last)
            report_mismatch($sformatf("ch %0d last got %0b exp %0b", exp_o.chan, last,
                                      exp_o.is_last));
          if (divide_fault !== exp_o.fault)
            report_mismatch($sformatf("ch %0d divide_fault got %0b exp %0b", exp_o.chan,
                                      divide_fault, exp_o.fault));
        end
      end
    end
  end

endmodule

FILE: dv/temperature_linear_attention_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_linear_attention_tb: top-level testbench
// Drives directed and randomized key/value/query sequences through the block
// under three idling regimes and several eps settings; a checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module temperature_linear_attention_tb;
  import tla_pkg::*;

  localparam int DIM = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 60;
  localparam int TARGET_REQUESTS = 160;
  localparam int PHASE_REQUESTS = 30;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         op;
  logic [3:0]         elem_index;
  logic signed [15:0] datum;
  logic signed [15:0] temperature;
  logic               out_valid;
  logic               out_stall;
  logic [3:0]         channel;
  logic signed [15:0] result_value;
  logic               last;
  logic               divide_fault;
  logic               cfg_we;
  logic [15:0]        cfg_wdata;

  int          fails;
  int          pending;
  int          results_seen;
  int          faults_seen;
  int          sats_seen;
  int          requests_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  int          stall_count;
  logic [15:0] keys_written;
  logic [15:0] queries_written;
  logic        zero_query;

  temperature_linear_attention uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .elem_index(elem_index), .datum(datum), .temperature(temperature),
    .out_valid(out_valid), .out_stall(out_stall),
    .channel(channel), .result_value(result_value), .last(last),
    .divide_fault(divide_fault),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  tla_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .elem_index(elem_index), .datum(datum), .temperature(temperature),
    .out_valid(out_valid), .out_stall(out_stall),
    .channel(channel), .result_value(result_value), .last(last),
    .divide_fault(divide_fault),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .results_seen(results_seen),
    .faults_seen(faults_seen), .sats_seen(sats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results still expected", pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long counted hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // operand mix weighted toward the extremes
  function automatic logic signed [15:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(8191))) - 16'sd4096;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // one request; called and returning at a falling edge
  task automatic send_request(input logic [1:0] code, input logic [3:0] idx,
                              input logic signed [15:0] d, input logic signed [15:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    op          = code;
    elem_index  = idx;
    datum       = d;
    temperature = t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    requests_sent++;
    case (code)
      OP_CLEAR: begin
        keys_written    = '0;
        queries_written = '0;
      end
      OP_KEY:   keys_written[idx] = 1'b1;
      OP_QUERY: queries_written[idx] = 1'b1;
      default: ;
    endcase
  endtask

  // sender pause until every expected result has come and the block settled
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_eps(input logic [15:0] value);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // one well-formed step: keys, values, queries up to the final element
  task automatic attention_step();
    int order [DIM];
    int n;
    if (keys_written != '1) begin
      for (int i = 0; i < DIM; i++) order[i] = i;
      order.shuffle();
      for (int i = 0; i < DIM; i++)
        send_request(OP_KEY, 4'(order[i]), pick_operand(), pick_operand());
    end else begin
      n = $urandom_range(3);
      for (int i = 0; i < n; i++)
        send_request(OP_KEY, 4'($urandom_range(DIM - 1)), pick_operand(), pick_operand());
    end
    n = $urandom_range(4, 1);
    for (int i = 0; i < n; i++)
      send_request(OP_VALUE, 4'($urandom_range(DIM - 1)), pick_operand(), pick_operand());
    zero_query = ($urandom_range(3) == 0);
    for (int i = 0; i < DIM; i++)
      send_request(OP_QUERY, 4'(i), zero_query ? 16'sd0 : pick_operand(), pick_operand());
  endtask

  // noise: a single legal request of any kind
  task automatic noise_request();
    logic [1:0] code;
    logic [3:0] idx;
    code = 2'($urandom_range(3));
    idx  = 4'($urandom_range(DIM - 1));
    if (code == OP_VALUE && keys_written != '1) code = OP_KEY;
    if (code == OP_QUERY && idx == DIM - 1 && queries_written != '1) idx = 0;
    send_request(code, idx, pick_operand(), pick_operand());
  endtask

  task automatic random_phase(input int quota);
    int start;
    start = requests_sent;
    while (requests_sent - start < quota) begin
      if ($urandom_range(4) == 0) noise_request();
      else attention_step();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_CLEAR;
    elem_index = '0;
    datum = '0;
    temperature = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    requests_sent = 0;
    keys_written = '0;
    queries_written = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: extreme keys/values/queries under default-like eps
    write_eps(16'd1);
    send_request(OP_CLEAR, 4'd5, 16'sh7FFF, 16'sh8000);
    for (int i = 0; i < DIM; i++)
      send_request(OP_KEY, 4'(i), (i % 2) ? 16'sh8000 : 16'sh7FFF,
                   (i % 3) ? 16'sh8000 : 16'sh7FFF);
    send_request(OP_VALUE, 4'd0, 16'sh7FFF, 16'sd0);
    send_request(OP_VALUE, 4'd15, 16'sh8000, 16'sh7FFF);
    for (int i = 0; i < DIM; i++)
      send_request(OP_QUERY, 4'(i), (i < 8) ? 16'sh7FFF : 16'sh8000, 16'sd0);

    // zero divisor: eps zero with an all-zero query vector
    write_eps(16'd0);
    for (int i = 0; i < DIM; i++) send_request(OP_QUERY, 4'(i), 16'sd0, 16'sd0);

    // sender idles often, receiver idles very often
    tx_idle_pct = 31;
    rx_idle_pct = 82;
    random_phase(PHASE_REQUESTS);

    write_eps(16'hFFFF);
    tx_idle_pct = 82;
    rx_idle_pct = 31;
    random_phase(PHASE_REQUESTS);

    write_eps(16'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    random_phase((TARGET_REQUESTS - requests_sent > PHASE_REQUESTS) ?
                 TARGET_REQUESTS - requests_sent : PHASE_REQUESTS);

    drain();
    $display("requests %0d, results %0d (divide faults %0d, saturated %0d)",
             requests_sent, results_seen, faults_seen, sats_seen);
    $display("eps 1/0/max/random, three idling regimes, long output hold-off");
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tla_pkg.sv
rtl/tla_ram.sv
rtl/tla_ctrl.sv
rtl/tla_datapath.sv
rtl/temperature_linear_attention.sv
dv/tla_checker.sv
dv/temperature_linear_attention_tb.sv
